// File: rtl/reliable_channel_sequencer_defines.svh
// Assertion macros shared by the channel sequencer RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef RELIABLE_CHANNEL_SEQUENCER_DEFINES_SVH
`define RELIABLE_CHANNEL_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every clock edge out of reset
`define RCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rcs: same-cycle check failed");

// Next-cycle implication
`define RCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rcs: next-cycle check failed");

`else

`define RCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/rcs_pkg.sv
package rcs_pkg;

    localparam int LEN_W = 11;
    localparam int SEQ_W = 31;
    localparam int WORD_W = 32;

    // command codes
    localparam logic CMD_TX = 1'b0;
    localparam logic CMD_RX = 1'b1;

    // configuration register indexes
    localparam logic CFG_IS_CLIENT = 1'b0;
    localparam logic CFG_QPORT     = 1'b1;

    typedef struct packed {
        logic              command;
        logic [LEN_W-1:0]  pending_bytes;
        logic              pending_overflow;
        logic [LEN_W-1:0]  unreliable_bytes;
        logic [WORD_W-1:0] rx_first_word;
        logic [WORD_W-1:0] rx_second_word;
    } t_item;

    typedef struct packed {
        logic              fatal_overflow;
        logic [WORD_W-1:0] first_header_word;
        logic [WORD_W-1:0] second_header_word;
        logic              reliable_sent;
        logic [LEN_W-1:0]  reliable_bytes_sent;
        logic              unreliable_sent;
        logic [LEN_W-1:0]  packet_bytes;
        logic              pending_taken;
        logic              packet_accepted;
        logic [SEQ_W-1:0]  packets_dropped;
    } t_result;

endpackage

// File: rtl/rcs_core.sv
module rcs_core
    import rcs_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 1400
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    input  logic    i_is_client,
    output t_result o_result
);

    // wide enough for header + qport + two full lengths and the limit
    localparam int SIZE_W = $clog2(MAX_PACKET_BYTES + 4104);
    localparam logic [SIZE_W-1:0] PKT_CAP  = SIZE_W'(MAX_PACKET_BYTES);
    localparam logic [SIZE_W-1:0] LIMIT    = SIZE_W'(MAX_PACKET_BYTES - 9);
    localparam logic [SIZE_W-1:0] HDR_SIZE = SIZE_W'(8);

    logic [SEQ_W-1:0] r_next_send, n_next_send;
    logic [SEQ_W-1:0] r_last_rx, n_last_rx;
    logic [SEQ_W-1:0] r_peer_ack, n_peer_ack;
    logic             r_peer_ack_bit, n_peer_ack_bit;
    logic             r_rx_rel_bit, n_rx_rel_bit;
    logic             r_tx_rel_bit, n_tx_rel_bit;
    logic [SEQ_W-1:0] r_last_rel_send, n_last_rel_send;
    logic [LEN_W-1:0] r_held, n_held;

    logic             overflow;
    logic             send_rel;
    logic             take;
    logic [LEN_W-1:0] held_now;
    logic [SIZE_W-1:0] base_size;
    logic [SIZE_W-1:0] total_size;
    logic             unrel_ok;
    logic [SEQ_W-1:0] rx_seq;

    // one item's decisions and the state it leaves behind
    always_comb begin
        n_next_send     = r_next_send;
        n_last_rx       = r_last_rx;
        n_peer_ack      = r_peer_ack;
        n_peer_ack_bit  = r_peer_ack_bit;
        n_rx_rel_bit    = r_rx_rel_bit;
        n_tx_rel_bit    = r_tx_rel_bit;
        n_last_rel_send = r_last_rel_send;
        n_held          = r_held;
        o_result        = '0;

        overflow = i_item.pending_overflow || (SIZE_W'(i_item.pending_bytes) > LIMIT);
        send_rel = (r_peer_ack > r_last_rel_send) && (r_peer_ack_bit != r_tx_rel_bit);
        take     = (r_held == '0) && (i_item.pending_bytes != '0);
        if (take) begin
            send_rel = 1'b1;
        end
        held_now   = take ? i_item.pending_bytes : r_held;
        base_size  = HDR_SIZE + SIZE_W'(i_is_client)
                   + (send_rel ? SIZE_W'(held_now) : '0);
        total_size = base_size + SIZE_W'(i_item.unreliable_bytes);
        unrel_ok   = (total_size <= PKT_CAP);
        rx_seq     = i_item.rx_first_word[SEQ_W-1:0];

        case (i_item.command)
            CMD_TX: begin
                if (overflow) begin
                    o_result.fatal_overflow = 1'b1;
                end else begin
                    if (take) begin
                        n_held       = i_item.pending_bytes;
                        n_tx_rel_bit = ~r_tx_rel_bit;
                    end
                    n_next_send = r_next_send + 1'b1;
                    if (send_rel) begin
                        n_last_rel_send = r_next_send + 1'b1;
                    end
                    o_result.first_header_word   = {send_rel, r_next_send};
                    o_result.second_header_word  = {r_rx_rel_bit, r_last_rx};
                    o_result.reliable_sent       = send_rel;
                    o_result.reliable_bytes_sent = send_rel ? held_now : '0;
                    o_result.unreliable_sent     = unrel_ok;
                    o_result.packet_bytes = unrel_ok ? total_size[LEN_W-1:0]
                                                     : base_size[LEN_W-1:0];
                    o_result.pending_taken       = take;
                end
            end
            CMD_RX: begin
                // stale or duplicate sequences leave everything alone
                if (rx_seq > r_last_rx) begin
                    o_result.packet_accepted = 1'b1;
                    o_result.packets_dropped = rx_seq - r_last_rx - 1'b1;
                    if (i_item.rx_second_word[WORD_W-1] == r_tx_rel_bit) begin
                        n_held = '0;
                    end
                    n_last_rx      = rx_seq;
                    n_peer_ack     = i_item.rx_second_word[SEQ_W-1:0];
                    n_peer_ack_bit = i_item.rx_second_word[WORD_W-1];
                    if (i_item.rx_first_word[WORD_W-1]) begin
                        n_rx_rel_bit = ~r_rx_rel_bit;
                    end
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    // channel state, committed as the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_send     <= SEQ_W'(1);
            r_last_rx       <= '0;
            r_peer_ack      <= '0;
            r_peer_ack_bit  <= 1'b0;
            r_rx_rel_bit    <= 1'b0;
            r_tx_rel_bit    <= 1'b0;
            r_last_rel_send <= '0;
            r_held          <= '0;
        end else if (i_advance) begin
            r_next_send     <= n_next_send;
            r_last_rx       <= n_last_rx;
            r_peer_ack      <= n_peer_ack;
            r_peer_ack_bit  <= n_peer_ack_bit;
            r_rx_rel_bit    <= n_rx_rel_bit;
            r_tx_rel_bit    <= n_tx_rel_bit;
            r_last_rel_send <= n_last_rel_send;
            r_held          <= n_held;
        end
    end

endmodule

// File: rtl/reliable_channel_sequencer.sv
// Reliable channel sequencer: header sequencing of one datagram channel.
// Path: an accepted item is held in the input register, then its result in the result
// register; throughput one item per cycle while the output is not stalled, set by the
// single pass of compare/add logic between the two registers.
// Reset (i_rst_n low, synchronous): pipeline empty, sequence state to its
// initial values (send sequence 1, all else 0), is_client cleared.
`include "reliable_channel_sequencer_defines.svh"

module reliable_channel_sequencer
    import rcs_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 1400
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    // input items
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_command,
    input  logic [LEN_W-1:0]  i_pending_bytes,
    input  logic              i_pending_overflow,
    input  logic [LEN_W-1:0]  i_unreliable_bytes,
    input  logic [WORD_W-1:0] i_rx_first_word,
    input  logic [WORD_W-1:0] i_rx_second_word,
    // result items
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_fatal_overflow,
    output logic [WORD_W-1:0] o_first_header_word,
    output logic [WORD_W-1:0] o_second_header_word,
    output logic              o_reliable_sent,
    output logic [LEN_W-1:0]  o_reliable_bytes_sent,
    output logic              o_unreliable_sent,
    output logic [LEN_W-1:0]  o_packet_bytes,
    output logic              o_pending_taken,
    output logic              o_packet_accepted,
    output logic [SEQ_W-1:0]  o_packets_dropped
);

    logic    r_is_client;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    logic    out_advance;
    logic    in_advance;

    // configuration; the qport byte itself rides with the payload elsewhere
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_client <= 1'b0;
        end else if (i_cfg_valid && (i_cfg_index == CFG_IS_CLIENT)) begin
            r_is_client <= i_cfg_data[0];
        end
    end

    // pipeline flow
    assign out_advance = r_in_valid && (!r_out_valid || !i_stall);
    assign in_advance  = !r_in_valid || out_advance;
    assign o_stall     = !in_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_advance) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_advance && i_valid) begin
            r_in.command          <= i_command;
            r_in.pending_bytes    <= i_pending_bytes;
            r_in.pending_overflow <= i_pending_overflow;
            r_in.unreliable_bytes <= i_unreliable_bytes;
            r_in.rx_first_word    <= i_rx_first_word;
            r_in.rx_second_word   <= i_rx_second_word;
        end
    end

    rcs_core #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (out_advance),
        .i_item      (r_in),
        .i_is_client (r_is_client),
        .o_result    (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_advance) begin
            r_out <= core_result;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_fatal_overflow      = r_out.fatal_overflow;
    assign o_first_header_word   = r_out.first_header_word;
    assign o_second_header_word  = r_out.second_header_word;
    assign o_reliable_sent       = r_out.reliable_sent;
    assign o_reliable_bytes_sent = r_out.reliable_bytes_sent;
    assign o_unreliable_sent     = r_out.unreliable_sent;
    assign o_packet_bytes        = r_out.packet_bytes;
    assign o_pending_taken       = r_out.pending_taken;
    assign o_packet_accepted     = r_out.packet_accepted;
    assign o_packets_dropped     = r_out.packets_dropped;

    // a refused transmit carries no header
    `RCS_ASSERT_IMPLY(a_ovf_no_header, i_clk, i_rst_n, o_valid && o_fatal_overflow, o_first_header_word == '0 && o_packet_bytes == '0 && !o_reliable_sent)
    // an accepted receive item never reports transmit fields
    `RCS_ASSERT_IMPLY(a_rx_no_tx, i_clk, i_rst_n, o_valid && o_packet_accepted, !o_fatal_overflow && !o_reliable_sent && !o_pending_taken && o_packet_bytes == '0)
    // input side stalls only when both registers are full
    `RCS_ASSERT_IMPLY(a_stall_full, i_clk, i_rst_n, o_stall, r_in_valid && r_out_valid && i_stall)
    // a stalled input item is still in the input register next cycle
    `RCS_ASSERT_NEXT(a_stall_keeps, i_clk, i_rst_n, o_stall, r_in_valid)

endmodule
